[rtl/frwm_pkg.sv]
// Shared constants, types and codes of the frame rate weighted window meter.
package frwm_pkg;

  localparam int WINDOW     = 60;
  localparam int IDX_W      = $clog2(WINDOW);
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int TIME_W     = 48;
  localparam int IV_W       = 32;
  localparam int WT_W       = 17;
  localparam int MOM_W      = 16;
  localparam int TPS_W      = 32;
  localparam int SW_W       = WT_W + $clog2(WINDOW);
  localparam int PROD_W     = IV_W + WT_W;
  localparam int SWD_W      = PROD_W + $clog2(WINDOW);
  localparam int NUM_W      = SWD_W;
  localparam int RATE_W     = 20;
  localparam int QB         = RATE_W + 1;
  localparam int STEP_W     = $clog2(QB);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [WT_W-1:0]   WEIGHT_ONE = WT_W'(65536);
  localparam logic [TPS_W-1:0]  TPS_RESET  = TPS_W'(1000000000);
  localparam logic [MOM_W-1:0]  MOM_RESET  = MOM_W'(64913);
  localparam logic [RATE_W-1:0] RATE_MAX   = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_TPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOM = 1'b1;

  typedef logic [TIME_W-1:0] frame_time_t;
  typedef logic [IV_W-1:0]   interval_t;
  typedef logic [IDX_W-1:0]  slot_t;
  typedef logic [RATE_W-1:0] rate_t;

  typedef struct packed {
    logic start;
    logic issue;
  } acc_ctrl_t;

endpackage

[rtl/frwm_if.sv]
// Valid/ready channel interfaces for frame timestamps and rate results.
interface frwm_in_if;
  import frwm_pkg::*;

  logic        valid;
  logic        ready;
  frame_time_t frame_time;

  modport source (output valid, output frame_time, input ready);
  modport sink (input valid, input frame_time, output ready);
endinterface

interface frwm_out_if;
  import frwm_pkg::*;

  logic  valid;
  logic  ready;
  rate_t rate_estimate;
  logic  window_full;

  modport source (output valid, output rate_estimate, output window_full, input ready);
  modport sink (input valid, input rate_estimate, input window_full, output ready);
endinterface

[rtl/frwm_ring.sv]
// Interval ring memory with one write port and one registered read port.
module frwm_ring (
  input  logic               clk,
  input  logic               wr_en,
  input  frwm_pkg::slot_t    wr_addr,
  input  frwm_pkg::interval_t wr_data,
  input  logic               rd_en,
  input  frwm_pkg::slot_t    rd_addr,
  output frwm_pkg::interval_t rd_data
);
  import frwm_pkg::*;

  interval_t mem [WINDOW];
  interval_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/frwm_accum.sv]
// Weighted multiply-accumulate over intervals streamed from the ring.
module frwm_accum (
  input  logic                     clk,
  input  logic                     rst_n,
  input  frwm_pkg::acc_ctrl_t      ctrl,
  input  logic [frwm_pkg::MOM_W-1:0] momentum,
  input  frwm_pkg::interval_t      rd_data,
  output logic [frwm_pkg::SW_W-1:0]  sum_w,
  output logic [frwm_pkg::SWD_W-1:0] sum_wd,
  output logic                     idle
);
  import frwm_pkg::*;

  logic [WT_W-1:0]        w_r;
  logic [WT_W-1:0]        w1_r;
  logic [WT_W+MOM_W-1:0]  w_prod;
  logic [PROD_W-1:0]      prod_r;
  logic [SW_W-1:0]        sum_w_r;
  logic [SWD_W-1:0]       sum_wd_r;
  logic                   v1_r;
  logic                   v2_r;

  assign w_prod = w_r * momentum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ctrl.start) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctrl.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      w_r      <= WEIGHT_ONE;
      sum_w_r  <= '0;
      sum_wd_r <= '0;
    end else begin
      if (ctrl.issue) begin
        w_r     <= w_prod[WT_W+MOM_W-1:MOM_W];
        w1_r    <= w_r;
        sum_w_r <= sum_w_r + SW_W'(w_r);
      end
      if (v1_r) begin
        prod_r <= w1_r * rd_data;
      end
      if (v2_r) begin
        sum_wd_r <= sum_wd_r + SWD_W'(prod_r);
      end
    end
  end

  assign sum_w  = sum_w_r;
  assign sum_wd = sum_wd_r;
  assign idle   = !v1_r && !v2_r;

endmodule

[rtl/frwm_div.sv]
// Rate numerator multiply and serial restoring divider with saturation.
module frwm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [frwm_pkg::TPS_W-1:0] tps,
  input  logic [frwm_pkg::SW_W-1:0]  sum_w,
  input  logic [frwm_pkg::SWD_W-1:0] sum_wd,
  output logic                       done,
  output frwm_pkg::rate_t            quot
);
  import frwm_pkg::*;

  localparam logic D_IDLE = 1'b0;
  localparam logic D_ITER = 1'b1;

  logic                    state_r;
  logic [STEP_W-1:0]       step_r;
  logic [NUM_W-1:0]        rem_r;
  logic [SWD_W+RATE_W-1:0] dsh_r;
  logic [QB-1:0]           q_r;
  logic                    zero_r;
  logic                    done_r;
  logic                    fits;

  assign fits = {{RATE_W{1'b0}}, rem_r} >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            state_r <= D_ITER;
          end
        end
        D_ITER: begin
          if (step_r == STEP_W'(QB - 1)) begin
            state_r <= D_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == D_IDLE) begin
      if (start) begin
        rem_r  <= NUM_W'(tps) * NUM_W'(sum_w);
        dsh_r  <= {sum_wd, {RATE_W{1'b0}}};
        zero_r <= (sum_wd == '0);
        q_r    <= '0;
        step_r <= '0;
      end
    end else begin
      if (fits) begin
        rem_r <= rem_r - dsh_r[NUM_W-1:0];
      end
      q_r    <= {q_r[QB-2:0], fits};
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r + 1'b1;
    end
  end

  assign done = done_r;
  assign quot = (zero_r || q_r[QB-1]) ? RATE_MAX : q_r[RATE_W-1:0];

endmodule

[rtl/frame_rate_weighted_window_meter_core.sv]
// Top level of the frame rate weighted window meter: control, configuration and channels.
//
//   Channel   Dir  Contents
//   in_ch     in   frame_time word (48 bits)
//   out_ch    out  rate_estimate (20 bits), window_full
//   cfg_*     in   write enable, register index, 32-bit write data
//
// Before the window is full a word passes from the accept cycle straight to loading the result
// into the output register.
// With a full window a word passes through the accept cycle, one ring read per window
// entry, the multiply-accumulate drain, the numerator multiply and divide, and the load of
// the output register.
// One word is in work at a time; the next is accepted once the result sits in the output
// register, even while that result is still stalled.
// Reset is synchronous and active low; the ring contents are not cleared.
module frame_rate_weighted_window_meter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  frwm_in_if.sink                         in_ch,
  frwm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [frwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frwm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import frwm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_r;
  logic [TPS_W-1:0]  tps_r;
  logic [MOM_W-1:0]  mom_r;
  slot_t             write_slot_r;
  logic [CNT_W-1:0]  fill_r;
  frame_time_t       prev_time_r;
  logic              seen_first_r;
  slot_t             rd_addr_r;
  slot_t             k_r;
  rate_t             res_rate_r;
  logic              res_full_r;
  logic              out_valid_r;
  rate_t             out_rate_r;
  logic              out_full_r;

  logic              accept;
  logic              load;
  frame_time_t       delta_full;
  interval_t         interval;
  logic [CNT_W-1:0]  fill_nxt;
  logic              full_now;
  acc_ctrl_t         acc_ctrl;
  logic [SW_W-1:0]   sum_w;
  logic [SWD_W-1:0]  sum_wd;
  logic              acc_idle;
  interval_t         rd_data;
  logic              div_start;
  logic              div_done;
  rate_t             quot;

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign delta_full = seen_first_r ? (in_ch.frame_time - prev_time_r) : '0;
  assign interval   = (|delta_full[TIME_W-1:IV_W]) ? '1 : delta_full[IV_W-1:0];
  assign fill_nxt   = (fill_r < CNT_W'(WINDOW)) ? fill_r + 1'b1 : fill_r;
  assign full_now   = (fill_nxt == CNT_W'(WINDOW));
  assign load       = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign div_start  = (state_r == S_DRAIN) && acc_idle;

  assign acc_ctrl.start = accept && full_now;
  assign acc_ctrl.issue = (state_r == S_MAC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
      mom_r <= MOM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TPS: tps_r <= cfg_wdata[TPS_W-1:0];
        CFG_MOM: mom_r <= cfg_wdata[MOM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      write_slot_r <= '0;
      fill_r       <= '0;
      prev_time_r  <= '0;
      seen_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            seen_first_r <= 1'b1;
            prev_time_r  <= in_ch.frame_time;
            fill_r       <= fill_nxt;
            write_slot_r <= (write_slot_r == IDX_W'(WINDOW - 1)) ? '0 : write_slot_r + 1'b1;
            state_r      <= full_now ? S_MAC : S_DONE;
          end
        end
        S_MAC: begin
          if (k_r == IDX_W'(WINDOW - 1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (acc_idle) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addr_r  <= write_slot_r;
      k_r        <= '0;
      res_rate_r <= '0;
      res_full_r <= 1'b0;
    end
    if (state_r == S_MAC) begin
      rd_addr_r <= (rd_addr_r == '0) ? IDX_W'(WINDOW - 1) : rd_addr_r - 1'b1;
      k_r       <= k_r + 1'b1;
    end
    if ((state_r == S_DIV) && div_done) begin
      res_rate_r <= quot;
      res_full_r <= 1'b1;
    end
    if (load) begin
      out_rate_r <= res_rate_r;
      out_full_r <= res_full_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rate_estimate = out_rate_r;
  assign out_ch.window_full   = out_full_r;

  frwm_ring u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (write_slot_r),
    .wr_data (interval),
    .rd_en   (acc_ctrl.issue),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  frwm_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (acc_ctrl),
    .momentum (mom_r),
    .rd_data  (rd_data),
    .sum_w    (sum_w),
    .sum_wd   (sum_wd),
    .idle     (acc_idle)
  );

  frwm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .tps    (tps_r),
    .sum_w  (sum_w),
    .sum_wd (sum_wd),
    .done   (div_done),
    .quot   (quot)
  );

  a_partial_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.window_full |-> out_ch.rate_estimate == '0)
    else $error("Result before a full window carries a nonzero rate.");

  a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW) && write_slot_r <= IDX_W'(WINDOW - 1))
    else $error("Fill count or write slot out of range.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("Input accepted again before the previous word finished.");

endmodule

[test/frwm_meter_checker.sv]
// Checker that predicts the rate word for every accepted frame timestamp and compares it.
module frwm_meter_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  frwm_in_if                              in_ch,
  frwm_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [frwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frwm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatch_count,
  output int                              words_pending
);
  import frwm_pkg::*;

  typedef struct packed {
    rate_t rate;
    logic  full;
  } rate_word_t;

  interval_t        gap_ring [WINDOW];
  slot_t            fill_slot;
  int               frames_held;
  frame_time_t      last_stamp;
  logic             have_stamp;
  logic [TPS_W-1:0] ticks_per_sec;
  logic [MOM_W-1:0] momentum;
  int               words_checked;
  rate_word_t       rate_words_due [$];

  function automatic rate_t weighted_rate();
    logic [63:0] weight;
    logic [63:0] weight_sum;
    logic [63:0] weighted_gaps;
    logic [63:0] quotient;
    slot_t       pos;
    weight        = 64'(WEIGHT_ONE);
    weight_sum    = '0;
    weighted_gaps = '0;
    pos           = fill_slot;
    for (int k = 0; k < WINDOW; k++) begin
      pos = (pos == '0) ? slot_t'(WINDOW - 1) : pos - 1'b1;
      weighted_gaps += weight * 64'(gap_ring[pos]);
      weight_sum    += weight;
      weight = (weight * 64'(momentum)) >> 16;
    end
    if (weighted_gaps == '0) return RATE_MAX;
    quotient = (64'(ticks_per_sec) * weight_sum) / weighted_gaps;
    return (quotient > 64'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
  endfunction

  task automatic flag_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: word %0d %s expected %0d, got %0d", $time, words_checked, field,
               want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_time_t stamp_gap;
    rate_word_t  want;
    rate_word_t  due;
    if (!rst_n) begin
      fill_slot     = '0;
      frames_held   = 0;
      last_stamp    = '0;
      have_stamp    = 1'b0;
      ticks_per_sec = TPS_RESET;
      momentum      = MOM_RESET;
      rate_words_due.delete();
      mismatch_count = 0;
      words_checked  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TPS: ticks_per_sec = cfg_wdata[TPS_W-1:0];
          CFG_MOM: momentum = cfg_wdata[MOM_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (rate_words_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: word %0d arrived with nothing expected (rate %0d, full %0d)",
                     $time, words_checked, out_ch.rate_estimate, out_ch.window_full);
          end
        end else begin
          want = rate_words_due[0];
          rate_words_due.delete(0);
          if (out_ch.rate_estimate !== want.rate) begin
            flag_mismatch("rate_estimate", 64'(want.rate), 64'(out_ch.rate_estimate));
          end
          if (out_ch.window_full !== want.full) begin
            flag_mismatch("window_full", 64'(want.full), 64'(out_ch.window_full));
          end
        end
        words_checked++;
      end
      if (in_ch.valid && in_ch.ready) begin
        stamp_gap  = have_stamp ? frame_time_t'(in_ch.frame_time - last_stamp) : '0;
        have_stamp = 1'b1;
        last_stamp = in_ch.frame_time;
        gap_ring[fill_slot] = (stamp_gap > frame_time_t'(32'hFFFF_FFFF)) ? '1
                                                                           : stamp_gap[IV_W-1:0];
        fill_slot = (fill_slot == slot_t'(WINDOW - 1)) ? '0 : fill_slot + 1'b1;
        if (frames_held < WINDOW) frames_held++;
        if (frames_held < WINDOW) begin
          due.rate = '0;
          due.full = 1'b0;
        end else begin
          due.rate = weighted_rate();
          due.full = 1'b1;
        end
        rate_words_due.insert(rate_words_due.size(), due);
      end
    end
    words_pending <= rate_words_due.size();
  end

endmodule

[test/frame_rate_weighted_window_meter_core_tb.sv]
// Testbench top for the frame rate weighted window meter: stimulus, phases and verdict.
module frame_rate_weighted_window_meter_core_tb;
  import frwm_pkg::*;

  typedef enum int {
    GAP_NOMINAL,
    GAP_TINY,
    GAP_ZERO_RUN,
    GAP_WIDE,
    GAP_SCATTER,
    GAP_MIXED
  } gap_mode_t;

  localparam frame_time_t OPENING_STAMPS [14] = '{
    48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0005, 48'h0000_0000_0003,
    48'h0000_0000_0003, 48'h0001_0000_0003, 48'h0002_0000_0002, 48'h0002_0000_0003,
    48'h0002_00FE_502E, 48'h8000_0000_0000, 48'h8000_0000_0001, 48'h7FFF_FFFF_FFFF,
    48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatch_count;
  int                    words_pending;
  bit                    steady_flow;
  frame_time_t           stamp_now;
  logic [TPS_W-1:0]      tps_now;

  frwm_in_if  in_ch();
  frwm_out_if out_ch();

  frame_rate_weighted_window_meter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  frwm_meter_checker rate_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady_flow || ($urandom_range(99) >= 24);
    end
  end

  function automatic frame_time_t next_stamp(input gap_mode_t mode, input int n);
    logic [63:0] nominal;
    logic [63:0] spread;
    logic [63:0] gap;
    gap_mode_t   pick;
    int          roll;
    nominal = (tps_now >= 60) ? 64'(tps_now / 60) : 64'($urandom_range(1000, 1));
    spread  = nominal / 20;
    pick    = mode;
    if (mode == GAP_MIXED) begin
      roll = $urandom_range(99);
      if (roll < 60) pick = GAP_NOMINAL;
      else if (roll < 72) pick = GAP_ZERO_RUN;
      else if (roll < 82) pick = GAP_TINY;
      else if (roll < 92) pick = GAP_WIDE;
      else pick = GAP_SCATTER;
    end
    case (pick)
      GAP_TINY:     gap = 64'($urandom_range(8));
      GAP_ZERO_RUN: gap = (n < 90 || mode == GAP_MIXED) ? '0 : nominal;
      GAP_WIDE: begin
        if ($urandom_range(3) == 0) gap = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
        else gap = 64'($urandom);
      end
      GAP_SCATTER:  return frame_time_t'({$urandom, $urandom});
      default:      gap = nominal - spread + 64'($urandom_range(32'(2 * spread)));
    endcase
    return frame_time_t'(64'(stamp_now) + gap);
  endfunction

  task automatic send_frame(input frame_time_t stamp);
    while (!steady_flow && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.frame_time <= stamp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [TPS_W-1:0] tps, input logic [MOM_W-1:0] mom,
                           input gap_mode_t mode, input int count, input bit steady);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TPS;
    cfg_wdata <= CFG_DATA_W'(tps);
    @(posedge clk);
    cfg_index <= CFG_MOM;
    cfg_wdata <= CFG_DATA_W'(mom);
    @(posedge clk);
    cfg_we      <= 1'b0;
    steady_flow <= steady;
    tps_now = tps;
    for (int n = 0; n < count; n++) begin
      stamp_now = next_stamp(mode, n);
      send_frame(stamp_now);
    end
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.frame_time <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_TPS;
    cfg_wdata        <= '0;
    steady_flow      <= 1'b0;
    rst_n            <= 1'b0;
    stamp_now = '0;
    tps_now   = TPS_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING_STAMPS[i]) send_frame(OPENING_STAMPS[i]);
    stamp_now = OPENING_STAMPS[13];

    run_phase(TPS_RESET, MOM_RESET, GAP_NOMINAL, 200, 1'b0);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, GAP_TINY, 180, 1'b0);
    run_phase(32'd1, 16'd0, GAP_NOMINAL, 180, 1'b0);
    run_phase(32'd90000, MOM_RESET, GAP_ZERO_RUN, 200, 1'b1);
    run_phase($urandom, 16'($urandom_range(65535)), GAP_WIDE, 200, 1'b0);
    run_phase(32'd0, 16'($urandom_range(65535)), GAP_MIXED, 150, 1'b0);
    run_phase(32'd1000000000, 16'd32768, GAP_SCATTER, 150, 1'b0);
    run_phase($urandom, 16'($urandom_range(65535)), GAP_MIXED, 380, 1'b0);

    drain();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/frwm_pkg.sv
rtl/frwm_if.sv
rtl/frwm_ring.sv
rtl/frwm_accum.sv
rtl/frwm_div.sv
rtl/frame_rate_weighted_window_meter_core.sv
test/frwm_meter_checker.sv
test/frame_rate_weighted_window_meter_core_tb.sv
